FILE: hw/rtl/wcbb_pkg.sv
// Shared types, constants and codes for the waveform column bar builder.
package wcbb_pkg;

    localparam int MAX_IMAGE_SIZE = 4096;
    localparam int MAX_CHANNELS   = 8;

    localparam int SAMPLE_W  = 16;
    localparam int MAG_W     = 16;
    localparam int ACC_W     = 35;
    localparam int CNT_W     = 20;
    localparam int COLCNT_W  = 13;
    localparam int CH_W      = 4;
    localparam int FPC_W     = 16;
    localparam int INV_W     = 24;
    localparam int DIM_W     = 13;
    localparam int ROW_W     = 12;
    localparam int LEVEL_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Accumulator is multiplied in two halves through one 18 x 24 multiplier.
    localparam int ACC_LO_W = 18;
    localparam int ACC_HI_W = ACC_W - ACC_LO_W;
    localparam int MUL_A_W  = ACC_LO_W;
    localparam int MUL_P_W  = MUL_A_W + INV_W;
    localparam int PROD_W   = ACC_W + INV_W;
    localparam int FRAC_W   = 24;
    localparam int SPAN_P_W = LEVEL_W + ROW_W;

    localparam logic [CH_W-1:0]     RST_CHANNELS  = 4'd2;
    localparam logic [FPC_W-1:0]    RST_FPC       = 16'd1;
    localparam logic [INV_W-1:0]    RST_INV_SCALE = 24'd8388608;
    localparam logic [DIM_W-1:0]    RST_HEIGHT    = 13'd256;
    localparam logic [DIM_W-1:0]    RST_WIDTH     = 13'd1024;

    localparam logic [LEVEL_W-1:0]  LEVEL_ONE     = 16'd32768;
    localparam logic [COLCNT_W-1:0] COLCNT_MAX    = 13'd8191;
    localparam logic [DIM_W-1:0]    DIM_MAX       = DIM_W'(MAX_IMAGE_SIZE);
    localparam logic [DIM_W-1:0]    HEIGHT_MIN    = 13'd2;
    localparam logic [CH_W-1:0]     CH_MAX        = CH_W'(MAX_CHANNELS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS      = 3'd0,
        CFG_FRAMES_PER_COL = 3'd1,
        CFG_INVERSE_SCALE = 3'd2,
        CFG_IMAGE_HEIGHT  = 3'd3,
        CFG_IMAGE_WIDTH   = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_LEVEL,
        ST_SPAN,
        ST_LOAD
    } t_ctrl_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0]   column;
        logic [LEVEL_W-1:0] level;
        logic [ROW_W-1:0]   bar_top;
        logic [ROW_W-1:0]   bar_bottom;
        logic               bar_present;
    } t_out_item;

    typedef struct packed {
        logic take_sample;
        logic mul_lo;
        logic mul_hi;
        logic calc_level;
        logic calc_span;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic col_close;
        logic col_emit;
        logic out_free;
    } t_dp_status;

endpackage

FILE: hw/rtl/wcbb_datapath.sv
// Datapath: configuration, sample accumulation, scaling multiplier, bar span, output register.
module wcbb_datapath
    import wcbb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_item              i_in_data,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data
);

    logic [CH_W-1:0]     r_channels;
    logic [FPC_W-1:0]    r_fpc;
    logic [INV_W-1:0]    r_inv_scale;
    logic [DIM_W-1:0]    r_height;
    logic [DIM_W-1:0]    r_width;

    logic [ACC_W-1:0]    r_acc;
    logic [CNT_W-1:0]    r_cnt;
    logic [COLCNT_W-1:0] r_col_cnt;
    logic                r_finished;

    logic [ACC_W-1:0]    r_acc_snap;
    logic [ROW_W-1:0]    r_col;
    logic [PROD_W-1:0]   r_prod;
    logic [LEVEL_W-1:0]  r_level;
    logic [ROW_W-1:0]    r_t;

    logic                r_out_valid;
    t_out_item           r_out;

    logic [MAG_W-1:0]    w_mag;
    logic [ACC_W-1:0]    n_acc;
    logic [CNT_W-1:0]    n_cnt;
    logic [CH_W-1:0]     w_ch_eff;
    logic [FPC_W-1:0]    w_fpc_eff;
    logic [CNT_W-1:0]    w_col_size;
    logic [DIM_W-1:0]    w_width_eff;
    logic [DIM_W-1:0]    w_h_eff;
    logic [ROW_W-1:0]    w_d;
    logic                w_close;
    logic [MUL_A_W-1:0]  w_mul_a;
    logic [MUL_P_W-1:0]  w_mul_p;
    logic [ACC_W-1:0]    w_q;
    logic [LEVEL_W-1:0]  n_level;
    logic [SPAN_P_W-1:0] w_span_p;
    logic [DIM_W-1:0]    w_top;
    logic [DIM_W-1:0]    w_bot;
    logic                w_present;
    logic                w_out_take;

    // Effective register values after range clamping.
    always_comb begin
        if (r_channels == '0) begin
            w_ch_eff = CH_W'(1);
        end else if (r_channels > CH_MAX) begin
            w_ch_eff = CH_MAX;
        end else begin
            w_ch_eff = r_channels;
        end
        w_fpc_eff   = (r_fpc == '0) ? FPC_W'(1) : r_fpc;
        w_width_eff = (r_width > DIM_MAX) ? DIM_MAX : r_width;
        if (r_height < HEIGHT_MIN) begin
            w_h_eff = HEIGHT_MIN;
        end else if (r_height > DIM_MAX) begin
            w_h_eff = DIM_MAX;
        end else begin
            w_h_eff = r_height;
        end
        w_d        = ROW_W'(w_h_eff - DIM_W'(1));
        w_col_size = CNT_W'(w_ch_eff * w_fpc_eff);
    end

    // Accumulate the magnitude of the incoming sample.
    always_comb begin
        w_mag   = i_in_data.sample[SAMPLE_W-1]
                ? MAG_W'(~i_in_data.sample + SAMPLE_W'(1))
                : MAG_W'(i_in_data.sample);
        n_acc   = r_acc + ACC_W'(w_mag);
        n_cnt   = r_cnt + CNT_W'(1);
        w_close = (n_cnt >= w_col_size) || i_in_data.end_of_data;
    end

    assign o_status.col_close = !r_finished && w_close;
    assign o_status.col_emit  = !r_finished && w_close && (r_col_cnt < w_width_eff);
    assign w_out_take         = r_out_valid && !i_out_stall;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    // Shared multiplier: low half of the accumulator, then high half.
    always_comb begin
        w_mul_a = i_cmd.mul_hi ? MUL_A_W'(r_acc_snap[ACC_W-1:ACC_LO_W])
                               : r_acc_snap[ACC_LO_W-1:0];
        w_mul_p = w_mul_a * r_inv_scale;
        w_q     = r_prod[PROD_W-1:FRAC_W];
        n_level = (w_q > ACC_W'(LEVEL_ONE)) ? LEVEL_ONE : w_q[LEVEL_W-1:0];
        w_span_p = r_level * w_d;
        w_top   = ({1'b0, w_d} - {1'b0, r_t} + DIM_W'(1)) >> 1;
        w_bot   = ({1'b0, w_d} + {1'b0, r_t}) >> 1;
        w_present = (w_top <= w_bot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channels  <= RST_CHANNELS;
            r_fpc       <= RST_FPC;
            r_inv_scale <= RST_INV_SCALE;
            r_height    <= RST_HEIGHT;
            r_width     <= RST_WIDTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNELS:       r_channels  <= i_cfg_data[CH_W-1:0];
                CFG_FRAMES_PER_COL: r_fpc       <= i_cfg_data[FPC_W-1:0];
                CFG_INVERSE_SCALE:  r_inv_scale <= i_cfg_data[INV_W-1:0];
                CFG_IMAGE_HEIGHT:   r_height    <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_WIDTH:    r_width     <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_cnt      <= '0;
            r_col_cnt  <= '0;
            r_finished <= 1'b0;
        end else if (i_cmd.take_sample && !r_finished) begin
            if (w_close) begin
                r_acc <= '0;
                r_cnt <= '0;
                if (r_col_cnt != COLCNT_MAX) begin
                    r_col_cnt <= r_col_cnt + COLCNT_W'(1);
                end
            end else begin
                r_acc <= n_acc;
                r_cnt <= n_cnt;
            end
            if (i_in_data.end_of_data) begin
                r_finished <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample && o_status.col_emit) begin
            r_acc_snap <= n_acc;
            r_col      <= r_col_cnt[ROW_W-1:0];
        end
        if (i_cmd.mul_lo) begin
            r_prod <= PROD_W'(w_mul_p);
        end else if (i_cmd.mul_hi) begin
            r_prod <= r_prod + {w_mul_p[ACC_HI_W+INV_W-1:0], {ACC_LO_W{1'b0}}};
        end
        if (i_cmd.calc_level) begin
            r_level <= n_level;
        end
        if (i_cmd.calc_span) begin
            r_t <= w_span_p[LEVEL_W-2+ROW_W:LEVEL_W-1];
        end
        if (i_cmd.load_out) begin
            r_out.column      <= r_col;
            r_out.level       <= r_level;
            r_out.bar_top     <= w_present ? w_top[ROW_W-1:0] : '0;
            r_out.bar_bottom  <= w_present ? w_bot[ROW_W-1:0] : '0;
            r_out.bar_present <= w_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("finished flag cleared without reset");

    a_close_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.take_sample && o_status.col_close) |=> (r_cnt == '0 && r_acc == '0))
        else $error("column close did not clear accumulation");

    a_valid_rises_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.load_out))
        else $error("output valid rose without a load");

    a_valid_falls_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_valid) |-> $past(!i_out_stall))
        else $error("output beat dropped while stalled");

endmodule

FILE: hw/rtl/wcbb_ctrl.sv
// Controller: sequences accumulation, the two-pass scale multiply, span and output load.
module wcbb_ctrl
    import wcbb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_ACC: begin
                o_in_stall        = 1'b0;
                o_cmd.take_sample = i_in_valid;
                if (i_in_valid && i_status.col_emit) begin
                    n_state = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_LEVEL;
            end
            ST_LEVEL: begin
                o_cmd.calc_level = 1'b1;
                n_state          = ST_SPAN;
            end
            ST_SPAN: begin
                o_cmd.calc_span = 1'b1;
                n_state         = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_ACC;
                end
            end
            default: begin
                n_state = ST_ACC;
            end
        endcase
    end

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_status.out_free)
        else $error("output register overwritten");

    a_emit_starts_multiply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take_sample && i_status.col_emit) |=> (r_state == ST_MUL_LO))
        else $error("emitting column did not start scaling");

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ACC) |-> !o_cmd.take_sample)
        else $error("sample taken while a column is in flight");

endmodule

FILE: hw/rtl/waveform_column_bar_builder_unit.sv
// Top level of the waveform column bar builder: controller plus datapath.
// Throughput: one sample beat per cycle while a column fills; a column that is
//   reported holds off input through the two-pass 18x24 scale multiply, level
//   saturation, span multiply and output load, longer if the output stays stalled.
// The result passes r_acc_snap, r_prod, r_level and r_t to the output register.
// Reset (i_rst_n low, synchronous): registers return to defaults, accumulator,
//   sample count, column counter and end-of-data flag clear, no output valid.
module waveform_column_bar_builder_unit
    import wcbb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Sample input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    // Column result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    // Commands from the controller, status back from the datapath.
    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequence the work: accept samples, then walk a closed column through
    // the scaling steps and park the result in the output register.
    wcbb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // Hold configuration, accumulate magnitudes, scale and build the bar.
    // The output register decouples the result beat from new input beats.
    wcbb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
